// ----- design/tsc_pkg.sv -----
// shared transaction types and codes for the timestamp pair compare block
package tsc_pkg;

    // order codes of a result
    localparam logic [1:0] ORDER_EQUAL = 2'd0;
    localparam logic [1:0] ORDER_EARLIER = 2'd1;
    localparam logic [1:0] ORDER_LATER = 2'd2;

    localparam logic [31:0] APART_THRESHOLD_RESET = 32'd172800;

    typedef struct packed {
        logic [6:0] first_year;
        logic [3:0] first_month;
        logic [4:0] first_day;
        logic [4:0] first_hour;
        logic [5:0] first_minute;
        logic [5:0] first_second;
        logic [6:0] second_year;
        logic [3:0] second_month;
        logic [4:0] second_day;
        logic [4:0] second_hour;
        logic [5:0] second_minute;
        logic [5:0] second_sec;
    } t_req;

    typedef struct packed {
        logic [31:0] first_seconds;
        logic [31:0] second_seconds;
        logic [1:0]  order_code;
        logic        apart_flag;
    } t_rsp;

endpackage

// ----- design/timestamp_pair_compare_top.sv -----
// top level: two calendar timestamps to seconds since 2000, compare and threshold
//
// channel   direction  handshake            payload
// request   in         start && !busy       i_req  (t_req, both timestamps)
// result    out        o_strobe, one cycle  o_rsp  (t_rsp, counts, order, apart)
// config    in         i_cfg_we             i_cfg_wdata (apart threshold)
//
// one transaction is taken every cycle; busy is held low
// a result passes the stage 1, stage 2, stage 3 and output registers in that order
// the stages: day count and time of day, day count times 86400, add and clamp,
// compare; the day multiply sets the stage depth
// reset clears the stage valid bits and loads the threshold with 172800 seconds
// the receiver cannot stall, so results leave on a fixed schedule
module timestamp_pair_compare_top
    import tsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_strobe,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    // day-of-year base per month code: (m+2)*611/20 - 92, less 2 from march on
    function automatic logic signed [9:0] month_base(input logic [3:0] m);
        logic signed [9:0] v;
        case (m)
            4'd0:    v = -10'sd31;
            4'd1:    v = -10'sd1;
            4'd2:    v = 10'sd30;
            4'd3:    v = 10'sd58;
            4'd4:    v = 10'sd89;
            4'd5:    v = 10'sd119;
            4'd6:    v = 10'sd150;
            4'd7:    v = 10'sd180;
            4'd8:    v = 10'sd211;
            4'd9:    v = 10'sd242;
            4'd10:   v = 10'sd272;
            4'd11:   v = 10'sd303;
            4'd12:   v = 10'sd333;
            4'd13:   v = 10'sd364;
            4'd14:   v = 10'sd394;
            4'd15:   v = 10'sd425;
            default: v = 10'sd0;
        endcase
        return v;
    endfunction

    // whole days since 2000-01-01, may be slightly negative for odd inputs
    function automatic logic signed [16:0] calc_days(input logic [6:0] yy,
                                                     input logic [3:0] mm,
                                                     input logic [4:0] dd);
        logic [15:0]       year_days;
        logic [5:0]        leap_days;
        logic signed [9:0] mb;
        logic              leap_fix;
        year_days = 16'(yy) * 16'd365;
        leap_days = 6'(({1'b0, yy} + 8'd3) >> 2);
        mb = month_base(mm);
        // leap day counts only from march on in a year divisible by four
        leap_fix = (mm >= 4'd3) && (yy[1:0] == 2'b00);
        return $signed({1'b0, year_days}) + $signed({11'b0, leap_days})
             + $signed({{7{mb[9]}}, mb}) + $signed({12'b0, dd})
             + $signed({16'b0, leap_fix});
    endfunction

    // seconds within the day, out-of-range fields keep their plain weights
    function automatic logic [16:0] calc_tod(input logic [4:0] hh,
                                             input logic [5:0] mn,
                                             input logic [5:0] ss);
        return 17'(hh) * 17'd3600 + 17'(mn) * 17'd60 + 17'(ss);
    endfunction

    // threshold register
    logic [31:0] r_threshold;

    // stage 1: day counts and time of day
    logic               r_s1_valid;
    logic signed [16:0] r_s1_days_a, r_s1_days_b;
    logic [16:0]        r_s1_tod_a, r_s1_tod_b;

    // stage 2: day counts scaled to seconds
    logic               r_s2_valid;
    logic signed [34:0] r_s2_prod_a, r_s2_prod_b;
    logic [16:0]        r_s2_tod_a, r_s2_tod_b;

    // stage 3: clamped totals
    logic               r_s3_valid;
    logic [31:0]        r_s3_sec_a, r_s3_sec_b;

    // stage 4: output register
    logic               r_out_valid;
    t_rsp               r_out;

    logic               accept;
    logic signed [34:0] n_tot_a, n_tot_b;
    logic signed [32:0] n_diff;
    logic [1:0]         n_order;
    logic               n_apart;
    t_rsp               n_out;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= APART_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_comb begin
        // add time of day; negative totals are clamped to zero at the stage 3 registers
        n_tot_a = r_s2_prod_a + $signed({18'b0, r_s2_tod_a});
        n_tot_b = r_s2_prod_b + $signed({18'b0, r_s2_tod_b});
    end

    always_comb begin
        // exact signed difference, no wrap
        n_diff = $signed({1'b0, r_s3_sec_a}) - $signed({1'b0, r_s3_sec_b});
        if (r_s3_sec_a < r_s3_sec_b) begin
            n_order = ORDER_EARLIER;
        end else if (r_s3_sec_a > r_s3_sec_b) begin
            n_order = ORDER_LATER;
        end else begin
            n_order = ORDER_EQUAL;
        end
        n_apart = (n_diff >= $signed({1'b0, r_threshold}));
        n_out.first_seconds  = r_s3_sec_a;
        n_out.second_seconds = r_s3_sec_b;
        n_out.order_code     = n_order;
        n_out.apart_flag     = n_apart;
    end

    // payload stages, no reset needed
    always_ff @(posedge i_clk) begin
        r_s1_days_a <= calc_days(i_req.first_year, i_req.first_month, i_req.first_day);
        r_s1_days_b <= calc_days(i_req.second_year, i_req.second_month, i_req.second_day);
        r_s1_tod_a  <= calc_tod(i_req.first_hour, i_req.first_minute, i_req.first_second);
        r_s1_tod_b  <= calc_tod(i_req.second_hour, i_req.second_minute, i_req.second_sec);

        r_s2_prod_a <= 35'(r_s1_days_a) * 35'sd86400;
        r_s2_prod_b <= 35'(r_s1_days_b) * 35'sd86400;
        r_s2_tod_a  <= r_s1_tod_a;
        r_s2_tod_b  <= r_s1_tod_b;

        r_s3_sec_a  <= n_tot_a[34] ? 32'd0 : n_tot_a[31:0];
        r_s3_sec_b  <= n_tot_b[34] ? 32'd0 : n_tot_b[31:0];

        r_out       <= n_out;
    end

    assign o_strobe = r_out_valid;
    assign o_rsp    = r_out;

endmodule

// ----- design/tsc_checker.sv -----
// port-level checks for the timestamp pair compare block, bound to the top level
module tsc_checker
    import tsc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input t_rsp        o_rsp
);

    // every accepted transaction yields its result strobe once it has passed the pipeline stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("result missing four cycles after accept");

    // no result without a matching earlier accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_rst_n, 4)) |-> $past(start && !busy, 4))
        else $error("result without matching transaction");

    // order code agrees with the two second counts
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |->
            ((o_rsp.order_code == ORDER_EQUAL
                && o_rsp.first_seconds == o_rsp.second_seconds)
          || (o_rsp.order_code == ORDER_EARLIER
                && o_rsp.first_seconds < o_rsp.second_seconds)
          || (o_rsp.order_code == ORDER_LATER
                && o_rsp.first_seconds > o_rsp.second_seconds)))
        else $error("order code disagrees with second counts");

    // a first timestamp that is not later can only be apart for a zero threshold
    a_apart_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.apart_flag && o_rsp.order_code != ORDER_LATER)
            |-> (o_rsp.first_seconds == o_rsp.second_seconds))
        else $error("apart flag set while first is earlier");

endmodule

bind timestamp_pair_compare_top tsc_checker u_tsc_checker (.*);
